FILE: design/isa_pkg.sv
`timescale 1ns / 1ps
// isa_pkg: shared types and constants for the indexed shift array
// no dependencies; used by every module of the block
package isa_pkg;

	// default sizes, handed down through the top level parameters
	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	// fixed field widths of the stream payloads
	localparam int OP_W     = 3;
	localparam int POS_W    = 6;
	localparam int ELEM_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// slot width covers the largest supported depth (1024 entries)
	localparam int SLOT_W = 10;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND    = 3'd0,
		OP_PREPEND   = 3'd1,
		OP_INSERT    = 3'd2,
		OP_POP_BACK  = 3'd3,
		OP_POP_FRONT = 3'd4,
		OP_REMOVE    = 3'd5,
		OP_GET       = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic              ins;   // open a gap at slot and load new element
		logic              rem;   // close the gap at slot
		logic [SLOT_W-1:0] slot;
	} cmd_t;

endpackage

FILE: design/indexed_shift_array.sv
`timescale 1ns / 1ps
// indexed_shift_array: ordered array with append, prepend, insert, pops, remove and get
// a result is registered and is valid in the cycle after its request is accepted
// throughput: one request per cycle unless stalled; every cell shifts in parallel on the same edge
// the output register frees up on the same edge it is taken; input waits only on a stalled result
// reset clears the fill count and the output valid; cell contents stay undefined until written
// depends on isa_pkg, isa_ctrl and isa_cell
module indexed_shift_array #(
	parameter int DEPTH = isa_pkg::DEPTH_DEF,   // number of cells, 1 to 1024
	parameter int WIDTH = isa_pkg::WIDTH_DEF    // bits stored per cell, 1 to 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [isa_pkg::IN_DATA_W-1:0]     s_tdata,  // opcode[2:0], position[8:3], element_in[40:9]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [isa_pkg::OUT_DATA_W-1:0]    m_tdata   // element_out[31:0], status[33:32],
	                                                    // count[38:34], is_empty[39]
);

	localparam int CW = $clog2(DEPTH + 1);           // fill count width, holds DEPTH itself
	localparam int XW = (WIDTH > isa_pkg::ELEM_W) ? WIDTH : isa_pkg::ELEM_W;
	localparam int KW = (CW > isa_pkg::COUNT_W) ? CW : isa_pkg::COUNT_W;

	// request fields
	logic [isa_pkg::OP_W-1:0]         opcode;
	logic signed [isa_pkg::POS_W-1:0] position;
	logic [isa_pkg::ELEM_W-1:0]       element_in;

	logic                 fire;
	logic [CW-1:0]        fill_count_q;
	logic [CW-1:0]        cnt_next;
	isa_pkg::cmd_t        cmd;
	isa_pkg::status_t     status;
	logic                 rd_ok;

	logic [XW-1:0]        elem_ext;
	logic [WIDTH-1:0]     elem_w;
	logic [WIDTH-1:0]     cell_q [DEPTH];
	logic [WIDTH-1:0]     rd_val;
	logic [XW-1:0]        rd_ext;
	logic [KW-1:0]        cnt_ext;

	// result register
	logic                               m_tvalid_q;
	logic [isa_pkg::ELEM_W-1:0]         element_out_q;
	isa_pkg::status_t                   status_q;
	logic [isa_pkg::COUNT_W-1:0]        count_q;
	logic                               is_empty_q;

	assign opcode     = s_tdata[2:0];
	assign position   = s_tdata[8:3];
	assign element_in = s_tdata[40:9];

	// accept whenever the result register is empty or being drained this cycle
	assign s_tready = !m_tvalid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	// element narrowed or widened to the cell width
	assign elem_ext = XW'(element_in);
	assign elem_w   = elem_ext[WIDTH-1:0];

	isa_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.fire     (fire),
		.opcode   (opcode),
		.position (position),
		.cnt      (fill_count_q),
		.cmd      (cmd),
		.status   (status),
		.rd_ok    (rd_ok),
		.cnt_next (cnt_next)
	);

	// row of cells; each hands its value to both neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] left;
		logic [WIDTH-1:0] right;

		if (i == 0) begin : g_first
			assign left = elem_w;               // never selected for the first cell
		end else begin : g_mid_l
			assign left = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right = cell_q[i];           // top cell holds on remove
		end else begin : g_mid_r
			assign right = cell_q[i+1];
		end

		isa_cell #(
			.WIDTH (WIDTH),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.din     (elem_w),
			.left    (left),
			.right   (right),
			.value_q (cell_q[i])
		);
	end

	// read port: each cell gates its value by a slot match, results are or'ed together
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.slot == isa_pkg::SLOT_W'(i)) begin
				rd_val = rd_val | cell_q[i];
			end
		end
	end

	assign rd_ext  = XW'(rd_val);
	assign cnt_ext = KW'(cnt_next);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
		end else if (fire) begin
			fill_count_q <= cnt_next;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload; element is zero unless something was read
	always_ff @(posedge clk) begin
		if (fire) begin
			element_out_q <= rd_ok ? rd_ext[isa_pkg::ELEM_W-1:0] : '0;
			status_q      <= status;
			count_q       <= cnt_ext[isa_pkg::COUNT_W-1:0];
			is_empty_q    <= (cnt_next == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {is_empty_q, count_q, status_q, element_out_q};

endmodule

FILE: design/isa_cell.sv
`timescale 1ns / 1ps
// isa_cell: one storage slot of the shift row
// depends on isa_pkg (cmd_t, SLOT_W)
module isa_cell #(
	parameter int WIDTH = isa_pkg::WIDTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  isa_pkg::cmd_t       cmd,
	input  logic [WIDTH-1:0]    din,
	input  logic [WIDTH-1:0]    left,
	input  logic [WIDTH-1:0]    right,
	output logic [WIDTH-1:0]    value_q
);

	localparam logic [isa_pkg::SLOT_W-1:0] ME = isa_pkg::SLOT_W'(IDX);

	// insert: slot loads new data, cells above take the left neighbor
	// remove: slot and cells above take the right neighbor
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (ME == cmd.slot) begin
				value_q <= din;
			end else if (ME > cmd.slot) begin
				value_q <= left;
			end
		end else if (cmd.rem && (ME >= cmd.slot)) begin
			value_q <= right;
		end
	end

endmodule

FILE: design/isa_ctrl.sv
`timescale 1ns / 1ps
// isa_ctrl: request decode, position mapping, status and next count
// depends on isa_pkg (op_t, status_t, cmd_t)
module isa_ctrl #(
	parameter  int DEPTH = isa_pkg::DEPTH_DEF,
	localparam int CW    = $clog2(DEPTH + 1)
) (
	input  logic                              fire,
	input  logic [isa_pkg::OP_W-1:0]          opcode,
	input  logic signed [isa_pkg::POS_W-1:0]  position,
	input  logic [CW-1:0]                     cnt,
	output isa_pkg::cmd_t                     cmd,
	output isa_pkg::status_t                  status,
	output logic                              rd_ok,
	output logic [CW-1:0]                     cnt_next
);

	localparam int EW = ((CW > isa_pkg::POS_W) ? CW : isa_pkg::POS_W) + 2;

	logic signed [EW-1:0] p_ext;
	logic signed [EW-1:0] cnt_ext;
	logic signed [EW-1:0] q_ext;
	logic                 full;
	logic                 empty;
	logic                 ins_ok;
	logic                 map_ok;
	logic                 ins;
	logic                 rem;

	assign p_ext   = EW'(position);
	assign cnt_ext = EW'(cnt);
	// negative positions count back from the end
	assign q_ext   = (p_ext < 0) ? (cnt_ext + p_ext) : p_ext;
	assign full    = (cnt == CW'(DEPTH));
	assign empty   = (cnt == '0);
	assign ins_ok  = (p_ext >= 0) && (p_ext <= cnt_ext);
	assign map_ok  = (q_ext >= 0) && (q_ext < cnt_ext);

	always_comb begin
		ins      = 1'b0;
		rem      = 1'b0;
		rd_ok    = 1'b0;
		status   = isa_pkg::ST_OK;
		cmd.slot = '0;
		unique case (isa_pkg::op_t'(opcode))
			isa_pkg::OP_APPEND: begin
				if (full) begin
					status = isa_pkg::ST_FULL;
				end else begin
					ins      = 1'b1;
					cmd.slot = isa_pkg::SLOT_W'(cnt);
				end
			end
			isa_pkg::OP_PREPEND: begin
				if (full) begin
					status = isa_pkg::ST_FULL;
				end else begin
					ins = 1'b1;
				end
			end
			isa_pkg::OP_INSERT: begin
				if (full) begin
					status = isa_pkg::ST_FULL;
				end else if (!ins_ok) begin
					status = isa_pkg::ST_RANGE;
				end else begin
					ins      = 1'b1;
					cmd.slot = isa_pkg::SLOT_W'(p_ext);
				end
			end
			isa_pkg::OP_POP_BACK: begin
				if (empty) begin
					status = isa_pkg::ST_RANGE;
				end else begin
					rem      = 1'b1;
					rd_ok    = 1'b1;
					cmd.slot = isa_pkg::SLOT_W'(CW'(cnt - 1'b1));
				end
			end
			isa_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status = isa_pkg::ST_RANGE;
				end else begin
					rem   = 1'b1;
					rd_ok = 1'b1;
				end
			end
			isa_pkg::OP_REMOVE: begin
				if (!map_ok) begin
					status = isa_pkg::ST_RANGE;
				end else begin
					rem      = 1'b1;
					rd_ok    = 1'b1;
					cmd.slot = isa_pkg::SLOT_W'(q_ext);
				end
			end
			isa_pkg::OP_GET: begin
				if (!map_ok) begin
					status = isa_pkg::ST_RANGE;
				end else begin
					rd_ok    = 1'b1;
					cmd.slot = isa_pkg::SLOT_W'(q_ext);
				end
			end
			default: begin
				status = isa_pkg::ST_RANGE;
			end
		endcase
		cmd.ins = ins & fire;
		cmd.rem = rem & fire;
	end

	always_comb begin
		if (ins) begin
			cnt_next = CW'(cnt + 1'b1);
		end else if (rem) begin
			cnt_next = CW'(cnt - 1'b1);
		end else begin
			cnt_next = cnt;
		end
	end

endmodule

FILE: design/isa_checker.sv
`timescale 1ns / 1ps
// isa_checker: port-level checks for the indexed shift array
// depends on isa_pkg; bound to indexed_shift_array below
module isa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [isa_pkg::IN_DATA_W-1:0]     s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [isa_pkg::OUT_DATA_W-1:0]    m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// empty flag agrees with the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39] == (m_tdata[38:34] == '0)))
		else $error("empty flag does not match count");

	// failed requests return a zero element
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:32] != isa_pkg::ST_OK) |-> (m_tdata[31:0] == '0))
		else $error("nonzero element on failed request");

	// an accepted request produces a result on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request gave no result");

endmodule

bind indexed_shift_array isa_checker u_isa_checker (.*);
